@@ design/lbm_d2q9_bgk_collision_top_defines.svh @@
// ---------------------------------------------------------------------------
// LBM collision assertion macros
// Shared property shapes for the collision block checks.
// ---------------------------------------------------------------------------
`ifndef LBM_D2Q9_BGK_COLLISION_TOP_DEFINES_SVH
`define LBM_D2Q9_BGK_COLLISION_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define LBMC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("lbmc check failed");

// next-cycle implication, masked during reset
`define LBMC_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("lbmc check failed");

// next-cycle implication, live during reset
`define LBMC_ASSERT_RST(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) (a) |=> (c)) \
        else $error("lbmc reset check failed");

`endif

@@ design/lbmc_pkg.sv @@
// ---------------------------------------------------------------------------
// LBM collision package
// Constants and lattice tables for the D2Q9 BGK collision block.
// ---------------------------------------------------------------------------
package lbmc_pkg;

    localparam int POP_WIDTH_DEF = 16;
    localparam int NDIR          = 9;
    localparam int OMEGA_W       = 16;
    localparam int OMEGA_FRAC    = 14;
    localparam logic [OMEGA_W-1:0] OMEGA_RESET = 16'd16384;

    localparam int KIND_W  = 2;
    localparam int TUSER_W = 8;
    localparam logic [KIND_W-1:0] KIND_WATER = 2'd0;

    localparam int WT_DEN = 36;

    localparam int WT_DIAG = 0;
    localparam int WT_AXIS = 1;
    localparam int WT_REST = 2;
    localparam int NWT     = 3;

    localparam int VEL_X    [NDIR] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
    localparam int VEL_Y    [NDIR] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
    localparam int WT_CLASS [NDIR] = '{WT_DIAG, WT_AXIS, WT_DIAG,
                                       WT_AXIS, WT_REST, WT_AXIS,
                                       WT_DIAG, WT_AXIS, WT_DIAG};
    // weight class -> log2 of weight * 36
    localparam int WT_SHIFT [NWT]  = '{0, 2, 4};

endpackage

@@ design/lbm_d2q9_bgk_collision_top.sv @@
// ---------------------------------------------------------------------------
// LBM D2Q9 BGK collision
// Streaming collision engine: one lattice cell per beat in, one relaxed
// cell per beat out.
// ---------------------------------------------------------------------------
// The block takes one cell every clock cycle while the output is not stalled;
// the velocity divider resolves one quotient bit per pipeline stage for both
// velocity components. Water cells with nonzero density are relaxed toward
// equilibrium by omega; all other cells leave unchanged. A stall on the
// output freezes the whole pipeline. omega is to be written through the cfg channel
// while the block is idle; the block itself does not enforce this.
`include "lbm_d2q9_bgk_collision_top_defines.svh"

module lbm_d2q9_bgk_collision_top #(
    parameter int POP_WIDTH = lbmc_pkg::POP_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pop_nw, pop_n, pop_ne, pop_w, pop_c, pop_e, pop_sw, pop_s, pop_se
    input  logic [((lbmc_pkg::NDIR*POP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cell_kind
    input  logic [lbmc_pkg::TUSER_W-1:0]                  s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // out_nw, out_n, out_ne, out_w, out_c, out_e, out_sw, out_s, out_se
    output logic [((lbmc_pkg::NDIR*POP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [lbmc_pkg::OMEGA_W-1:0]                  i_cfg_data
);

    localparam int ND   = lbmc_pkg::NDIR;
    localparam int P    = POP_WIDTH;
    localparam int F    = P - 2;
    localparam int TDW  = ((ND*P+7)/8)*8;
    localparam int RW   = P + 4;
    localparam int DW   = RW + F + 1;
    localparam int UW   = F + 2;
    localparam int VW   = F + 3;
    localparam int SQW  = 2*VW;
    localparam int USW  = 2*UW + 1;
    localparam int BW   = F + 7;
    localparam int XW   = RW + 4;
    localparam int SH   = XW + 6;
    localparam int MW   = RW + 1 + BW;
    localparam int FQW  = MW - F;
    localparam int QW   = FQW + 1;
    localparam int OW   = QW + lbmc_pkg::OMEGA_W + 1;
    localparam int NST  = F + 8;
    localparam int NWT  = lbmc_pkg::NWT;

    localparam logic [XW+1:0] RECIP = (XW+2)'((64'd1 << SH) / 64'(lbmc_pkg::WT_DEN));
    localparam logic signed [BW-1:0] ONE_Q = BW'(1) << F;

    typedef logic [ND-1:0][P-1:0] t_pops;

    typedef struct packed {
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [F:0]    qx;
        logic [F:0]    qy;
        logic          sx;
        logic          sy;
        logic [RW-1:0] rho;
        logic          act;
        t_pops         pop;
    } t_div;

    logic           w_en;
    logic [NST-1:0] r_vld;
    logic [lbmc_pkg::OMEGA_W-1:0] r_omega;

    assign w_en          = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NST-1];
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_omega <= lbmc_pkg::OMEGA_RESET;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                r_omega <= i_cfg_data;
            end
        end
    end

    // input stage
    t_pops                      r_a_pop;
    logic [lbmc_pkg::KIND_W-1:0] r_a_kind;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_pop  <= s_axis_tdata[ND*P-1:0];
            r_a_kind <= s_axis_tuser[lbmc_pkg::KIND_W-1:0];
        end
    end

    // density and momentum
    t_div n_b;
    t_div r_b;

    always_comb begin
        logic [RW-1:0]  rho;
        logic [P+1:0]   xp, xn, yp, yn;
        logic [P+1:0]   mx, my;
        rho = '0;
        for (int i = 0; i < ND; i++) begin
            rho = rho + RW'(r_a_pop[i]);
        end
        xp = (P+2)'(r_a_pop[2]) + (P+2)'(r_a_pop[5]) + (P+2)'(r_a_pop[8]);
        xn = (P+2)'(r_a_pop[0]) + (P+2)'(r_a_pop[3]) + (P+2)'(r_a_pop[6]);
        yp = (P+2)'(r_a_pop[6]) + (P+2)'(r_a_pop[7]) + (P+2)'(r_a_pop[8]);
        yn = (P+2)'(r_a_pop[0]) + (P+2)'(r_a_pop[1]) + (P+2)'(r_a_pop[2]);
        mx = (xp >= xn) ? (xp - xn) : (xn - xp);
        my = (yp >= yn) ? (yp - yn) : (yn - yp);
        n_b.rx  = DW'(mx) << F;
        n_b.ry  = DW'(my) << F;
        n_b.qx  = '0;
        n_b.qy  = '0;
        n_b.sx  = xp < xn;
        n_b.sy  = yp < yn;
        n_b.rho = rho;
        n_b.act = (r_a_kind == lbmc_pkg::KIND_WATER) && (rho != '0);
        n_b.pop = r_a_pop;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b <= n_b;
        end
    end

    // velocity divider, one quotient bit per stage
    t_div r_div [F+1];
    t_div w_src [F+1];
    t_div n_div [F+1];

    for (genvar k = 0; k <= F; k++) begin : g_div
        if (k == 0) begin : g_first
            assign w_src[k] = r_b;
        end else begin : g_rest
            assign w_src[k] = r_div[k-1];
        end

        always_comb begin
            logic [DW-1:0] d;
            n_div[k] = w_src[k];
            d = DW'(w_src[k].rho) << (F - k);
            if (w_src[k].rx >= d) begin
                n_div[k].rx         = w_src[k].rx - d;
                n_div[k].qx[F - k]  = 1'b1;
            end
            if (w_src[k].ry >= d) begin
                n_div[k].ry         = w_src[k].ry - d;
                n_div[k].qy[F - k]  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // projections, squares, weighted density estimate
    logic signed [VW-1:0]  r_c_vu  [ND];
    logic signed [SQW-1:0] r_c_vsq [ND];
    logic signed [USW-1:0] r_c_uu;
    logic [RW-1:0]         r_c_q0  [NWT];
    logic [RW-1:0]         r_c_rho;
    logic                  r_c_act;
    t_pops                 r_c_pop;

    logic signed [VW-1:0]  n_c_vu  [ND];
    logic signed [SQW-1:0] n_c_vsq [ND];
    logic signed [USW-1:0] n_c_uu;
    logic [RW-1:0]         n_c_q0  [NWT];

    always_comb begin
        logic signed [UW-1:0]  ux, uy;
        logic signed [VW-1:0]  vx, vy, vu;
        logic signed [USW-1:0] uxe, uye;
        logic [XW-1:0]         x;
        logic [2*XW+1:0]       pr;
        ux = UW'(r_div[F].qx);
        uy = UW'(r_div[F].qy);
        if (r_div[F].sx) begin
            ux = -ux;
        end
        if (r_div[F].sy) begin
            uy = -uy;
        end
        vx  = VW'(ux);
        vy  = VW'(uy);
        uxe = USW'(ux);
        uye = USW'(uy);
        n_c_uu = uxe*uxe + uye*uye;
        for (int i = 0; i < ND; i++) begin
            vu = '0;
            if (lbmc_pkg::VEL_X[i] > 0) begin
                vu = vu + vx;
            end else if (lbmc_pkg::VEL_X[i] < 0) begin
                vu = vu - vx;
            end
            if (lbmc_pkg::VEL_Y[i] > 0) begin
                vu = vu + vy;
            end else if (lbmc_pkg::VEL_Y[i] < 0) begin
                vu = vu - vy;
            end
            n_c_vu[i]  = vu;
            n_c_vsq[i] = SQW'(vu) * SQW'(vu);
        end
        for (int w = 0; w < NWT; w++) begin
            x  = XW'(r_div[F].rho) << lbmc_pkg::WT_SHIFT[w];
            pr = (2*XW+2)'(x) * (2*XW+2)'(RECIP);
            n_c_q0[w] = RW'(pr >> SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_vu  <= n_c_vu;
            r_c_vsq <= n_c_vsq;
            r_c_uu  <= n_c_uu;
            r_c_q0  <= n_c_q0;
            r_c_rho <= r_div[F].rho;
            r_c_act <= r_div[F].act;
            r_c_pop <= r_div[F].pop;
        end
    end

    // equilibrium bracket, corrected weighted density
    logic signed [BW-1:0] r_d_br [ND];
    logic [RW-1:0]        r_d_rw [NWT];
    logic                 r_d_act;
    t_pops                r_d_pop;

    logic signed [BW-1:0] n_d_br [ND];
    logic [RW-1:0]        n_d_rw [NWT];

    always_comb begin
        logic [USW-1:0]   usq;
        logic [USW:0]     t3;
        logic [SQW-1:0]   vs;
        logic [SQW+3:0]   t9;
        logic [SQW+3:0]   t2;
        logic signed [BW-1:0] vb;
        logic [XW-1:0]    x;
        logic [XW:0]      rem;
        usq = $unsigned(r_c_uu) >> F;
        t3  = ((USW+1)'(usq) + ((USW+1)'(usq) << 1)) >> 1;
        for (int i = 0; i < ND; i++) begin
            vs = $unsigned(r_c_vsq[i]) >> F;
            t9 = (SQW+4)'(vs) + ((SQW+4)'(vs) << 3);
            t2 = t9 >> 1;
            vb = BW'(r_c_vu[i]);
            n_d_br[i] = ONE_Q + vb + (vb <<< 1) + $signed(BW'(t2)) - $signed(BW'(t3));
        end
        for (int w = 0; w < NWT; w++) begin
            x   = XW'(r_c_rho) << lbmc_pkg::WT_SHIFT[w];
            rem = (XW+1)'(x) - (XW+1)'(r_c_q0[w]) * (XW+1)'(lbmc_pkg::WT_DEN);
            n_d_rw[w] = (rem >= (XW+1)'(lbmc_pkg::WT_DEN)) ? (r_c_q0[w] + RW'(1)) : r_c_q0[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_br  <= n_d_br;
            r_d_rw  <= n_d_rw;
            r_d_act <= r_c_act;
            r_d_pop <= r_c_pop;
        end
    end

    // equilibrium populations
    logic signed [FQW-1:0] r_e_feq [ND];
    logic                  r_e_act;
    t_pops                 r_e_pop;
    logic signed [FQW-1:0] n_e_feq [ND];

    always_comb begin
        logic signed [MW-1:0] m;
        for (int i = 0; i < ND; i++) begin
            m = $signed({1'b0, r_d_rw[lbmc_pkg::WT_CLASS[i]]}) * r_d_br[i];
            n_e_feq[i] = m[MW-1:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_feq <= n_e_feq;
            r_e_act <= r_d_act;
            r_e_pop <= r_d_pop;
        end
    end

    // relaxation product
    logic signed [OW-1:0] r_f_prod [ND];
    logic                 r_f_act;
    t_pops                r_f_pop;
    logic signed [OW-1:0] n_f_prod [ND];

    always_comb begin
        logic signed [QW-1:0] diff;
        for (int i = 0; i < ND; i++) begin
            diff = QW'(r_e_feq[i]) - $signed(QW'(r_e_pop[i]));
            n_f_prod[i] = $signed({1'b0, r_omega}) * diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_prod <= n_f_prod;
            r_f_act  <= r_e_act;
            r_f_pop  <= r_e_pop;
        end
    end

    // clamp, saturate, select pass-through
    t_pops r_g_pop;
    t_pops n_g_pop;

    always_comb begin
        logic signed [OW-1:0] sh;
        logic signed [OW:0]   rr;
        for (int i = 0; i < ND; i++) begin
            sh = r_f_prod[i] >>> lbmc_pkg::OMEGA_FRAC;
            rr = (OW+1)'(sh) + $signed((OW+1)'(r_f_pop[i]));
            if (!r_f_act) begin
                n_g_pop[i] = r_f_pop[i];
            end else if (rr[OW]) begin
                n_g_pop[i] = '0;
            end else if (|rr[OW-1:P]) begin
                n_g_pop[i] = '1;
            end else begin
                n_g_pop[i] = rr[P-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_pop <= n_g_pop;
        end
    end

    assign m_axis_tdata = TDW'(r_g_pop);

    `LBMC_ASSERT_RST(a_rst_clears_out, !i_rst_n, !m_axis_tvalid)
    `LBMC_ASSERT_NXT(a_stall_holds, !w_en, $stable(r_vld))
    `LBMC_ASSERT_IMP(a_accept_needs_room, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready)
    `LBMC_ASSERT_NXT(a_cfg_write, i_cfg_valid && o_cfg_ready, r_omega == $past(i_cfg_data))

endmodule
